// ----- hw/rtl/byte_ring_fifo_assert.svh -----
// Assertion macros for the byte ring FIFO.
// Used by byte_ring_fifo.sv; the module must provide clock and reset.
`ifndef BYTE_RING_FIFO_ASSERT_SVH
`define BYTE_RING_FIFO_ASSERT_SVH

`ifndef SYNTHESIS
// check on every edge outside reset
`define BRF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check on every edge, reset included
`define BRF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define BRF_ASSERT(label, prop, msg)
`define BRF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- hw/rtl/brf_pkg.sv -----
// Package for the byte ring FIFO: sizes, operation codes, payload and state types.
// No dependencies.
`timescale 1ns / 1ps

package brf_pkg;

   localparam int DEPTH     = 4096;
   localparam int MAX_BURST = 64;

   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int LEVEL_W = 13;
   localparam int BURST_W = $clog2(MAX_BURST + 1);
   localparam int CAP_W   = 13;

   localparam logic [2:0] FUNC_WRITE = 3'd0;
   localparam logic [2:0] FUNC_READ  = 3'd1;
   localparam logic [2:0] FUNC_PEEK  = 3'd2;
   localparam logic [2:0] FUNC_SKIP  = 3'd3;
   localparam logic [2:0] FUNC_CLEAR = 3'd4;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

   typedef struct packed {
      logic [2:0]         func;
      logic [7:0]         data_in;
      logic [LEVEL_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic [7:0]         data_out;
      logic               ok;
      logic               last;
      logic [LEVEL_W-1:0] level;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_BURST
   } state_type;

endpackage

// ----- hw/rtl/byte_ring_fifo.sv -----
// Byte ring FIFO top level: operation decode, ring pointers and byte store.
// Depends on brf_pkg and byte_ring_fifo_assert.svh.
`timescale 1ns / 1ps
`include "byte_ring_fifo_assert.svh"

// Channel  Direction  Payload          Handshake
// req_     in         brf_pkg::req_type req_valid / req_stall
// rsp_     out        brf_pkg::rsp_type rsp_valid / rsp_stall
// csr_     in/out     capacity (13 b)   APB-style, pready tied high
//
// Every operation is first captured, then executed against the pointers in
// the execute step. Read and peek then stream one byte per cycle out of the
// store (registered synchronous read port) while rsp_ does not stall. Reset
// is synchronous and needs no clearing pass; the store content is undefined
// until written. A stall on rsp_ holds the execute and burst steps; req_ is
// accepted whenever the block is idle.
module byte_ring_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  brf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output brf_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import brf_pkg::*;

   // byte store: one write port, one registered read port
   logic [7:0]        store_ff [DEPTH];
   logic [7:0]        mem_q_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   state_type          state_ff, state_in;
   req_type            op_ff;
   logic [ADDR_W-1:0]  read_pos_ff, read_pos_in;
   logic [ADDR_W-1:0]  write_pos_ff, write_pos_in;
   logic [LEVEL_W-1:0] fill_ff, fill_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [BURST_W-1:0] remain_ff, remain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_take;
   logic               cfg_we;
   logic               out_free;
   logic [LEVEL_W-1:0] size;
   logic [LEVEL_W-1:0] wp_inc;
   logic [ADDR_W-1:0]  wp_next;
   logic [LEVEL_W-1:0] pos_inc;
   logic [ADDR_W-1:0]  pos_next;
   logic [LEVEL_W-1:0] skip_sum;
   logic [ADDR_W-1:0]  skip_next;
   logic [BURST_W-1:0] cnt_clamp;
   logic [BURST_W-1:0] burst_n;

   // ------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   // the output register can take a result when empty or drained this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32 - CAP_W){1'b0}}, capacity_ff};
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0);

   // ------------------------------------------------------------------
   // Ring arithmetic
   // ------------------------------------------------------------------
   // clamp the register to 1..DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         size = LEVEL_W'(1);
      end else if (capacity_ff > CAP_W'(DEPTH)) begin
         size = LEVEL_W'(DEPTH);
      end else begin
         size = capacity_ff;
      end
   end

   // wrap by one compare: pointers stay below size, a skip is at most fill
   assign wp_inc    = LEVEL_W'(write_pos_ff) + LEVEL_W'(1);
   assign wp_next   = (wp_inc >= size) ? '0 : wp_inc[ADDR_W-1:0];
   assign pos_inc   = LEVEL_W'(pos_ff) + LEVEL_W'(1);
   assign pos_next  = (pos_inc >= size) ? '0 : pos_inc[ADDR_W-1:0];
   assign skip_sum  = LEVEL_W'(read_pos_ff) + op_ff.count;
   assign skip_next = (skip_sum >= size) ? ADDR_W'(skip_sum - size)
                                         : skip_sum[ADDR_W-1:0];

   // burst length: min(count, MAX_BURST, fill)
   assign cnt_clamp = (op_ff.count > LEVEL_W'(MAX_BURST)) ? BURST_W'(MAX_BURST)
                                                         : op_ff.count[BURST_W-1:0];
   assign burst_n   = (LEVEL_W'(cnt_clamp) > fill_ff) ? fill_ff[BURST_W-1:0] : cnt_clamp;

   // ------------------------------------------------------------------
   // Next state and outputs
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      read_pos_in  = read_pos_ff;
      write_pos_in = write_pos_ff;
      fill_in      = fill_ff;
      capacity_in  = capacity_ff;
      pos_in       = pos_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = write_pos_ff;
      mem_re       = 1'b0;
      mem_raddr    = read_pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               // default answer: one result, no byte
               rsp_data_in.data_out = '0;
               rsp_data_in.ok       = 1'b0;
               rsp_data_in.last     = 1'b1;
               state_in             = ST_IDLE;
               unique case (op_ff.func)
                  FUNC_WRITE: begin
                     if (fill_ff < size) begin
                        mem_we             = 1'b1;
                        write_pos_in       = wp_next;
                        fill_in            = fill_ff + LEVEL_W'(1);
                        rsp_data_in.ok     = 1'b1;
                     end
                  end
                  FUNC_READ, FUNC_PEEK: begin
                     if (burst_n != '0) begin
                        // start the burst: fetch the first byte, hold the result
                        mem_re    = 1'b1;
                        mem_raddr = read_pos_ff;
                        pos_in    = read_pos_ff;
                        remain_in = burst_n;
                        if (op_ff.func == FUNC_READ) begin
                           fill_in = fill_ff - LEVEL_W'(burst_n);
                        end
                        state_in  = ST_BURST;
                     end
                  end
                  FUNC_SKIP: begin
                     if (op_ff.count <= fill_ff) begin
                        read_pos_in    = skip_next;
                        fill_in        = fill_ff - op_ff.count;
                        rsp_data_in.ok = 1'b1;
                     end
                  end
                  FUNC_CLEAR: begin
                     read_pos_in    = '0;
                     write_pos_in   = '0;
                     fill_in        = '0;
                     rsp_data_in.ok = 1'b1;
                  end
                  default: begin
                     // unknown operation: answer ok=0, change nothing
                  end
               endcase
               rsp_data_in.level = fill_in;
               rsp_valid_in      = (state_in == ST_IDLE);
            end
         end
         ST_BURST: begin
            if (out_free) begin
               // hand out the fetched byte, prefetch the next one
               rsp_valid_in         = 1'b1;
               rsp_data_in.data_out = mem_q_ff;
               rsp_data_in.ok       = 1'b1;
               rsp_data_in.last     = (remain_ff == BURST_W'(1));
               rsp_data_in.level    = fill_ff;
               pos_in               = pos_next;
               remain_in            = remain_ff - BURST_W'(1);
               if (remain_ff != BURST_W'(1)) begin
                  mem_re    = 1'b1;
                  mem_raddr = pos_next;
               end else begin
                  if (op_ff.func == FUNC_READ) begin
                     read_pos_in = pos_next;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a capacity write empties the ring; the user must write it only while idle, the block does not enforce this
      if (cfg_we) begin
         capacity_in  = csr_pwdata[CAP_W-1:0];
         read_pos_in  = '0;
         write_pos_in = '0;
         fill_in      = '0;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         read_pos_ff  <= '0;
         write_pos_ff <= '0;
         fill_ff      <= '0;
         capacity_ff  <= CAP_RESET;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_pos_ff  <= read_pos_in;
         write_pos_ff <= write_pos_in;
         fill_ff      <= fill_in;
         capacity_ff  <= capacity_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
      if (req_take) begin
         op_ff <= req_data;
      end
   end

   // byte store; writes and burst reads belong to different transactions,
   // so a read never meets a write to the same entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= op_ff.data_in;
      end
      if (mem_re) begin
         mem_q_ff <= store_ff[mem_raddr];
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `BRF_ASSERT(a_fill_in_ring, (fill_ff <= size), "fill exceeds ring size")
   `BRF_ASSERT(a_rd_in_ring, (LEVEL_W'(read_pos_ff) < size), "read pointer beyond ring")
   `BRF_ASSERT(a_wr_in_ring, (LEVEL_W'(write_pos_ff) < size), "write pointer beyond ring")
   `BRF_ASSERT(a_take_to_exec, (req_take |=> (state_ff == ST_EXEC)), "transaction not run")
   `BRF_ASSERT(a_burst_remain, ((state_ff == ST_BURST) |-> (remain_ff != '0)), "empty burst")

endmodule
